### hw/rtl/bounded_sequence_list_engine_macros.svh
// ---------------------------------------------------------------------------
// bounded sequence list engine assertion macros
// shared property forms, sampled on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define BSLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bsle_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsle_pkg
// types and constants shared by the bounded sequence list engine
// ---------------------------------------------------------------------------
package bsle_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int OP_W           = 3;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 5;
  localparam int STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_REM_FIRST = 3'd4,
    OP_REM_ALL   = 3'd5,
    OP_LOOKUP    = 3'd6
  } op_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_RUN
  } fsm_state_t;

  // what every cell of the chain does in one cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS_FRONT,
    CELL_REM_FRONT,
    CELL_ADD_BACK,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     keep;
  } cell_ctl_t;

endpackage

### hw/rtl/bsle_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsle_cell
// one storage slot of the list chain, shifts toward either neighbor
// ---------------------------------------------------------------------------
module bsle_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int LEN_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  bsle_pkg::cell_ctl_t   ctl,
  input  logic [LEN_W-1:0]      len,
  input  logic [DATA_WIDTH-1:0] feed_d,
  input  logic [DATA_WIDTH-1:0] left_d,
  input  logic [DATA_WIDTH-1:0] right_d,
  output logic [DATA_WIDTH-1:0] data_q
);
  import bsle_pkg::*;

  localparam logic [LEN_W-1:0] MY_POS  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] NXT_POS = LEN_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_INS_FRONT: data_nxt = left_d;
      CELL_REM_FRONT: data_nxt = right_d;
      CELL_ADD_BACK: begin
        if (len == MY_POS) begin
          data_nxt = feed_d;
        end
      end
      CELL_ROTATE: begin
        // ring over the live cells, the last one takes the head if it survives
        priority if (NXT_POS < len) begin
          data_nxt = right_d;
        end else if (NXT_POS == len && ctl.keep) begin
          data_nxt = feed_d;
        end else begin
          data_nxt = data_r;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

### hw/rtl/bounded_sequence_list_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_sequence_list_engine
// ordered list of up to CAPACITY values held in a chain of shifting cells
// ---------------------------------------------------------------------------
// A request (in_operation, in_value) is taken on a rising edge with start
// high and busy low. Each request yields exactly one result, shown on the
// out_ ports for one cycle while out_valid is high; the receiver cannot stall,
// and busy is already low in that cycle, so the next request can be taken.
// Insert front/back, remove front and the unused code do their work in one
// pass over the chain: busy covers that pass, the result is registered at
// its end, and no new request is taken until busy falls.
// Remove back, remove first match, remove all matches and lookup rotate the
// live cells once past a single head comparator, the removals dropping
// entries on the way: one rotation step per entry held when the request was
// taken, then a closing step that registers the result.
// Synchronous reset empties the list and drops any request in flight; the
// cells themselves are not cleared and only positions below the count are
// ever read.
// ---------------------------------------------------------------------------
module bounded_sequence_list_engine #(
  parameter int CAPACITY   = bsle_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = bsle_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bsle_pkg::OP_W-1:0]     in_operation,
  input  logic [bsle_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [bsle_pkg::VALUE_W-1:0]  out_removed_value,
  output logic                          out_found,
  output logic [bsle_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_empty_res,
  output logic [bsle_pkg::STATUS_W-1:0] out_status
);
  import bsle_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_ZERO = '0;

  fsm_state_t            state_r, state_nxt;
  op_code_t              op_r, op_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic                  hit_r, hit_nxt;
  logic [DATA_WIDTH-1:0] removed_r, removed_nxt;

  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_removed_value_r;
  logic                  out_found_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_empty_res_r;
  status_t               out_status_r;

  logic                  done;
  logic [DATA_WIDTH-1:0] res_removed;
  logic                  res_found;
  logic [LEN_W-1:0]      res_cnt;
  status_t               res_status;

  cell_ctl_t             ctl;
  logic [DATA_WIDTH-1:0] feed;
  logic [DATA_WIDTH-1:0] head;
  logic                  match;
  logic                  drop;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  // -------------------------------------------------------------------------
  // cell chain
  // -------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = key_r;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    bsle_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .LEN_W      (LEN_W),
      .IDX        (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .len     (cnt_r),
      .feed_d  (feed),
      .left_d  (left_d),
      .right_d (right_d),
      .data_q  (cell_q[g])
    );
  end

  assign head  = cell_q[0];
  assign match = (head == key_r);

  // -------------------------------------------------------------------------
  // next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (start) begin
          state_nxt = FSM_RUN;
        end
      end
      FSM_RUN: begin
        if (done) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // datapath and result
  // -------------------------------------------------------------------------
  always_comb begin
    ctl         = '{op: CELL_HOLD, keep: 1'b0};
    feed        = key_r;
    drop        = 1'b0;
    op_nxt      = op_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    hit_nxt     = hit_r;
    removed_nxt = removed_r;
    done        = 1'b0;
    res_removed = '0;
    res_found   = 1'b0;
    res_cnt     = cnt_r;
    res_status  = ST_OK;

    unique case (state_r)
      FSM_IDLE: begin
        if (start) begin
          op_nxt      = op_code_t'(in_operation);
          key_nxt     = DATA_WIDTH'(in_value);
          rem_nxt     = cnt_r;
          hit_nxt     = 1'b0;
          removed_nxt = '0;
        end
      end
      FSM_RUN: begin
        unique case (op_r)
          OP_ADD_FRONT: begin
            done = 1'b1;
            if (cnt_r == LEN_FULL) begin
              res_status = ST_FULL;
            end else begin
              ctl.op  = CELL_INS_FRONT;
              cnt_nxt = cnt_r + LEN_ONE;
            end
          end
          OP_ADD_BACK: begin
            done = 1'b1;
            if (cnt_r == LEN_FULL) begin
              res_status = ST_FULL;
            end else begin
              ctl.op  = CELL_ADD_BACK;
              cnt_nxt = cnt_r + LEN_ONE;
            end
          end
          OP_REM_FRONT: begin
            done = 1'b1;
            if (cnt_r == LEN_ZERO) begin
              res_status = ST_UNDERFLOW;
            end else begin
              ctl.op      = CELL_REM_FRONT;
              cnt_nxt     = cnt_r - LEN_ONE;
              res_removed = head;
            end
          end
          OP_REM_BACK, OP_REM_FIRST, OP_REM_ALL, OP_LOOKUP: begin
            if (rem_r != LEN_ZERO) begin
              // one rotation step: head leaves cell 0, survivors rejoin at the tail
              unique case (op_r)
                OP_REM_BACK:  drop = (rem_r == LEN_ONE);
                OP_REM_FIRST: drop = match && !hit_r;
                OP_REM_ALL:   drop = match;
                default:      drop = 1'b0;
              endcase
              ctl.op   = CELL_ROTATE;
              ctl.keep = !drop;
              feed     = head;
              rem_nxt  = rem_r - LEN_ONE;
              if (drop) begin
                cnt_nxt = cnt_r - LEN_ONE;
              end
              if (op_r == OP_REM_BACK) begin
                hit_nxt = hit_r || drop;
                if (drop) begin
                  removed_nxt = head;
                end
              end else begin
                hit_nxt = hit_r || match;
              end
            end else begin
              done = 1'b1;
              if (op_r == OP_REM_BACK) begin
                res_removed = removed_r;
                res_status  = hit_r ? ST_OK : ST_UNDERFLOW;
              end else begin
                res_found = hit_r;
              end
            end
          end
          default: done = 1'b1;
        endcase
        res_cnt = cnt_nxt;
      end
      default: done = 1'b0;
    endcase
  end

  // -------------------------------------------------------------------------
  // registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    rem_r     <= rem_nxt;
    hit_r     <= hit_nxt;
    removed_r <= removed_nxt;
    if (done) begin
      out_removed_value_r <= VALUE_W'(res_removed);
      out_found_r         <= res_found;
      out_count_r         <= COUNT_W'(res_cnt);
      out_empty_res_r     <= (res_cnt == LEN_ZERO);
      out_status_r        <= res_status;
    end
  end

  assign busy              = (state_r == FSM_RUN);
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_value_r;
  assign out_found         = out_found_r;
  assign out_count         = out_count_r;
  assign out_empty_res     = out_empty_res_r;
  assign out_status        = out_status_r;

endmodule

### hw/rtl/bsle_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsle_checker
// port-level checks on the list engine, bound to the top level
// ---------------------------------------------------------------------------
`include "bounded_sequence_list_engine_macros.svh"

module bsle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [bsle_pkg::OP_W-1:0]     in_operation,
  input logic [bsle_pkg::VALUE_W-1:0]  in_value,
  input logic                          out_valid,
  input logic [bsle_pkg::VALUE_W-1:0]  out_removed_value,
  input logic                          out_found,
  input logic [bsle_pkg::COUNT_W-1:0]  out_count,
  input logic                          out_empty_res,
  input logic [bsle_pkg::STATUS_W-1:0] out_status
);
  import bsle_pkg::*;

  logic unused_in;
  assign unused_in = ^{in_operation, in_value};

  `BSLE_ASSERT_NEXT(a_accept_goes_busy, rst_n && start && !busy, busy, "request taken but engine not busy")
  `BSLE_ASSERT_IMPL(a_result_when_idle, out_valid, !busy, "result strobe while still busy")
  `BSLE_ASSERT_IMPL(a_empty_tracks_count, out_valid, out_empty_res == (out_count == '0), "empty flag disagrees with count")
  `BSLE_ASSERT_IMPL(a_underflow_empty, out_valid && out_status == ST_UNDERFLOW, out_empty_res && out_removed_value == '0, "underflow on a non-empty list")
  `BSLE_ASSERT_IMPL(a_found_is_ok, out_valid && out_found, out_status == ST_OK, "match reported with error status")

endmodule

bind bounded_sequence_list_engine bsle_checker u_bsle_checker (.*);
